/* rtl/core/farey_sequence_generator_core_defines.svh */
// Assertion macros shared by the Farey sequence generator RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef FAREY_SEQUENCE_GENERATOR_CORE_DEFINES_SVH
`define FAREY_SEQUENCE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/fsg_pkg.sv */
// Shared widths, phase codes and divider status type for the Farey sequence generator.
// No dependencies; used by fsg_div and farey_sequence_generator_core.
package fsg_pkg;

	localparam int ORDER_W = 8;
	localparam int DIVD_W  = ORDER_W + 1;
	localparam int CNT_W   = $clog2(DIVD_W);
	localparam int WIDE_W  = 2 * ORDER_W + 1;
	localparam int PROD_W  = WIDE_W + ORDER_W;

	// Sequence phase codes.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_REC    = 2'd2;
	localparam logic [1:0] PH_SPARE  = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/core/fsg_div.sv */
// Restoring divider, one quotient bit per cycle, for the Farey recurrence.
// Depends on fsg_pkg for widths and the status struct.
module fsg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fsg_pkg::DIVD_W-1:0]  dividend,
	input  logic [fsg_pkg::ORDER_W-1:0] divisor,
	output logic [fsg_pkg::DIVD_W-1:0]  quotient,
	output fsg_pkg::div_stat_t          stat
);
	import fsg_pkg::*;

	logic [ORDER_W-1:0] rem_q;
	logic [DIVD_W-1:0]  quo_q;
	logic [ORDER_W-1:0] dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ORDER_W:0]   trial;
	logic [ORDER_W:0]   diff;
	logic               fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ORDER_W-1:0] : trial[ORDER_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/core/farey_sequence_generator_core.sv */
// Farey sequence generator top level: sequencer, shared multiplier and output register.
// Depends on fsg_pkg, fsg_div and farey_sequence_generator_core_defines.svh.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, restart           | in
//  out     | out_valid, out_ready, numerator,      | out
//          | denominator, last                     |
//  cfg     | cfg_we, cfg_wdata (order)             | in
//
// A fresh 0/1, the term 1/n and the 1/1 of order one go into the result registers on accept.
// A recurrence term passes the bit-serial divider, six steps for the products, subtractions
// and checks, and the output register; a term cut short to 1/1 by a range check ends early
// at S_SUB or S_CHK. in_ready is high only while the sequencer is idle; a finished result
// waits in the result registers, and the sequencer holds in S_DONE until the output register
// can take it. Reset sets order to 1 and starts the sequence at 0/1.
`include "farey_sequence_generator_core_defines.svh"

module farey_sequence_generator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fsg_pkg::ORDER_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        restart,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fsg_pkg::ORDER_W-1:0] numerator,
	output logic [fsg_pkg::ORDER_W-1:0] denominator,
	output logic                        last
);
	import fsg_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_MA   = 4'd2;
	localparam logic [3:0] S_MB   = 4'd3;
	localparam logic [3:0] S_SUB  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_MD   = 4'd6;
	localparam logic [3:0] S_CMP  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]         state_q;
	logic [ORDER_W-1:0] order_q;
	logic [ORDER_W-1:0] n_eff;
	logic [1:0]         phase_q;
	logic [ORDER_W-1:0] prev_num_q;
	logic [ORDER_W-1:0] prev_den_q;
	logic [ORDER_W-1:0] cur_num_q;
	logic [ORDER_W-1:0] cur_den_q;
	logic [WIDE_W-1:0]  a_q;
	logic [WIDE_W-1:0]  num_q;
	logic [WIDE_W-1:0]  den_q;
	logic [PROD_W-1:0]  c_q;
	logic [PROD_W-1:0]  prod_q;
	logic [WIDE_W-1:0]  mul_x;
	logic [ORDER_W-1:0] mul_y;
	logic [ORDER_W-1:0] res_num_q;
	logic [ORDER_W-1:0] res_den_q;
	logic               res_last_q;
	logic               out_valid_q;
	logic [ORDER_W-1:0] out_num_q;
	logic [ORDER_W-1:0] out_den_q;
	logic               out_last_q;
	logic               accept;
	logic               load_out;
	logic               div_start;
	logic [DIVD_W-1:0]  div_quo;
	div_stat_t          div_stat;
	logic [WIDE_W-1:0]  k_wide;
	logic [WIDE_W-1:0]  b_val;

	assign n_eff    = (order_q == '0) ? ORDER_W'(1) : order_q;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign k_wide   = {{(WIDE_W - DIVD_W){1'b0}}, div_quo};
	assign b_val    = prod_q[WIDE_W-1:0];
	assign div_start = accept && !restart && (phase_q == PH_REC) && (cur_den_q != '0);

	fsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({1'b0, prev_den_q} + {1'b0, n_eff}),
		.divisor  (cur_den_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Operand selection for the shared multiplier; the product is registered.
	always_comb begin
		unique case (state_q)
			S_MA: begin
				mul_x = k_wide;
				mul_y = cur_num_q;
			end
			S_MB: begin
				mul_x = k_wide;
				mul_y = cur_den_q;
			end
			S_CHK: begin
				mul_x = num_q;
				mul_y = cur_den_q;
			end
			S_MD: begin
				mul_x = den_q;
				mul_y = cur_num_q;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_x) * PROD_W'(mul_y);
		if (state_q == S_MB)
			a_q <= prod_q[WIDE_W-1:0];
		if (state_q == S_SUB) begin
			num_q <= a_q - WIDE_W'(prev_num_q);
			den_q <= b_val - WIDE_W'(prev_den_q);
		end
		if (state_q == S_MD)
			c_q <= prod_q;
		if (load_out) begin
			out_num_q  <= res_num_q;
			out_den_q  <= res_den_q;
			out_last_q <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer. A term that fails any range check ends the sequence with 1/1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_FIRST;
			prev_num_q <= '0;
			prev_den_q <= ORDER_W'(1);
			cur_num_q  <= ORDER_W'(1);
			cur_den_q  <= ORDER_W'(1);
			res_num_q  <= '0;
			res_den_q  <= '0;
			res_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (restart || phase_q == PH_FIRST || phase_q == PH_SPARE) begin
							prev_num_q <= '0;
							prev_den_q <= ORDER_W'(1);
							phase_q    <= PH_SECOND;
							res_num_q  <= '0;
							res_den_q  <= ORDER_W'(1);
							res_last_q <= 1'b0;
							state_q    <= S_DONE;
						end else if (phase_q == PH_SECOND) begin
							if (n_eff == ORDER_W'(1)) begin
								phase_q    <= PH_FIRST;
								res_num_q  <= ORDER_W'(1);
								res_den_q  <= ORDER_W'(1);
								res_last_q <= 1'b1;
							end else begin
								prev_num_q <= '0;
								prev_den_q <= ORDER_W'(1);
								cur_num_q  <= ORDER_W'(1);
								cur_den_q  <= n_eff;
								phase_q    <= PH_REC;
								res_num_q  <= ORDER_W'(1);
								res_den_q  <= n_eff;
								res_last_q <= 1'b0;
							end
							state_q <= S_DONE;
						end else if (cur_den_q == '0) begin
							phase_q    <= PH_FIRST;
							res_num_q  <= ORDER_W'(1);
							res_den_q  <= ORDER_W'(1);
							res_last_q <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done)
						state_q <= S_MA;
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_SUB;
				S_SUB: begin
					if (a_q < WIDE_W'(prev_num_q) || b_val <= WIDE_W'(prev_den_q)) begin
						phase_q    <= PH_FIRST;
						res_num_q  <= ORDER_W'(1);
						res_den_q  <= ORDER_W'(1);
						res_last_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (den_q[WIDE_W-1:ORDER_W] != '0 || num_q >= den_q) begin
						phase_q    <= PH_FIRST;
						res_num_q  <= ORDER_W'(1);
						res_den_q  <= ORDER_W'(1);
						res_last_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_MD;
					end
				end
				S_MD: state_q <= S_CMP;
				S_CMP: begin
					// The new term must lie strictly above the current one.
					if (c_q <= prod_q) begin
						phase_q    <= PH_FIRST;
						res_num_q  <= ORDER_W'(1);
						res_den_q  <= ORDER_W'(1);
						res_last_q <= 1'b1;
					end else begin
						prev_num_q <= cur_num_q;
						prev_den_q <= cur_den_q;
						cur_num_q  <= num_q[ORDER_W-1:0];
						cur_den_q  <= den_q[ORDER_W-1:0];
						res_num_q  <= num_q[ORDER_W-1:0];
						res_den_q  <= den_q[ORDER_W-1:0];
						res_last_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign numerator   = out_num_q;
	assign denominator = out_den_q;
	assign last        = out_last_q;

	`FSG_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "input accepted while busy")
	`FSG_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_q == S_DIV, "stray divider done")
	`FSG_ASSERT_NOW(a_last_is_one, out_valid && last, numerator == 1 && denominator == 1,
		"last term is not 1/1")
	`FSG_ASSERT_NOW(a_term_below_one, out_valid && !last, numerator < denominator,
		"non-final term is not a proper fraction")

endmodule
